// ===== rtl/etss_pkg.sv =====
`default_nettype none

package etss_pkg;

  // Fixed geometry of the sequencer.
  localparam int unsigned RAMP_COUNTS = 100;
  localparam int unsigned COUNT_BITS  = 14;
  localparam int unsigned SUM_W       = COUNT_BITS + 4;
  localparam int unsigned DIF_W       = COUNT_BITS + 2;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Field widths.
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned CRUISE_W = 12;
  localparam int unsigned DECEL_W  = 7;
  localparam int unsigned SPEED_W  = 8;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = CRUISE_W;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 24;

  // Commands carried with each request.
  typedef enum logic [CMD_W-1:0] {
    CMD_RIGHT_ABOUT = 3'd0,
    CMD_LEFT_ABOUT  = 3'd1,
    CMD_RIGHT_HALF  = 3'd2,
    CMD_TURN_BACK   = 3'd3,
    CMD_TICK        = 3'd4
  } cmd_t;

  // Turn kinds, the low bits of the start command.
  localparam logic [1:0] KIND_RIGHT_ABOUT = 2'd0;
  localparam logic [1:0] KIND_LEFT_ABOUT  = 2'd1;
  localparam logic [1:0] KIND_RIGHT_HALF  = 2'd2;
  localparam logic [1:0] KIND_TURN_BACK   = 2'd3;

  // Drive mode codes.
  localparam logic [MODE_W-1:0] MODE_IDLE       = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SPIN_RIGHT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SPIN_LEFT  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BRAKE      = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_RIGHT_ABOUT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_LEFT_ABOUT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_HALF        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_BACK        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DECEL_FULL         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DECEL_HALF_LEN     = 3'd5;

  // Sequencer phases.
  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_ACCEL  = 4'b0010,
    PH_CRUISE = 4'b0100,
    PH_DECEL  = 4'b1000
  } phase_t;

  typedef struct packed {
    phase_t                  phase;
    logic [1:0]              turn_kind;
    logic [COUNT_BITS-1:0]   cruise_end;
    logic [COUNT_BITS-1:0]   decel_end;
    logic [SPEED_W-1:0]      left_base;
    logic [SPEED_W-1:0]      right_base;
  } seq_state_t;

  typedef struct packed {
    logic [CRUISE_W-1:0] cruise_right_about;
    logic [CRUISE_W-1:0] cruise_left_about;
    logic [CRUISE_W-1:0] cruise_half;
    logic [CRUISE_W-1:0] cruise_back;
    logic [DECEL_W-1:0]  decel_full;
    logic [DECEL_W-1:0]  decel_half_len;
  } seq_cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [COUNT_BITS-1:0] left_count;
    logic [COUNT_BITS-1:0] right_count;
  } seq_item_t;

  typedef struct packed {
    logic [SPEED_W-1:0] left_speed;
    logic [SPEED_W-1:0] right_speed;
    logic [MODE_W-1:0]  drive_mode;
    logic               clear_encoders;
    logic               turn_done;
  } seq_result_t;

  // Sigmoid table: 110/(1+r^(50-d)) in unsigned Q8.8, r = 2.73^0.05.
  localparam int unsigned SIG_DEPTH = 256;
  localparam int unsigned SIG_PIVOT = 50;
  localparam int unsigned POW_COUNT = 206;
  localparam logic [63:0] ONE_Q24   = 64'd16777216;
  localparam logic [63:0] RATIO_Q24 = 64'd17641197;
  localparam logic [63:0] SIG_SCALE = 64'd28160;

  typedef logic [15:0] sig_rom_t [SIG_DEPTH];

  // Shift-and-subtract quotient, only evaluated while the table is built.
  function automatic logic [63:0] long_quot(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic sig_rom_t build_sig_rom();
    logic [63:0] pw [POW_COUNT];
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] quo;
    int unsigned k;
    sig_rom_t    rom;
    pw[0] = ONE_Q24;
    for (int n = 1; n < POW_COUNT; n++) begin
      pw[n] = (pw[n-1] * RATIO_Q24 + (ONE_Q24 >> 1)) >> 24;
    end
    for (int d = 0; d < SIG_DEPTH; d++) begin
      k   = (d <= SIG_PIVOT) ? SIG_PIVOT - d : d - SIG_PIVOT;
      den = ONE_Q24 + pw[k];
      num = (d <= SIG_PIVOT) ? SIG_SCALE * ONE_Q24 : SIG_SCALE * pw[k];
      quo = long_quot((num << 1) + den, den << 1);
      rom[d] = quo[15:0];
    end
    return rom;
  endfunction

  localparam sig_rom_t SIG_ROM = build_sig_rom();

endpackage

`default_nettype wire

// ===== rtl/etss_step.sv =====
`default_nettype none

module etss_step (
  input  etss_pkg::seq_state_t  state,
  input  etss_pkg::seq_cfg_t    cfg,
  input  etss_pkg::seq_item_t   item,
  output etss_pkg::seq_state_t  state_nxt,
  output etss_pkg::seq_result_t result
);
  import etss_pkg::*;

  logic [1:0]              kind;
  logic [CRUISE_W-1:0]     cr_sel;
  logic [DECEL_W-1:0]      dl_sel;
  logic [SUM_W-1:0]        ce_sum;
  logic [SUM_W-1:0]        de_sum;
  logic [COUNT_BITS-1:0]   ce_sat;
  logic [COUNT_BITS-1:0]   de_sat;
  logic [COUNT_BITS-1:0]   lc;
  logic [COUNT_BITS-1:0]   rc;
  logic [COUNT_BITS-1:0]   ramp_cnt;
  logic [7:0]              acc_idx;
  logic [15:0]             acc_sig;
  logic [SPEED_W-1:0]      acc_speed;
  logic signed [DIF_W-1:0] dec_dif;
  logic [7:0]              dec_idx;
  logic [15:0]             dec_sig;
  logic [16:0]             dec_sum;
  logic [SPEED_W-1:0]      dec_cut;
  logic                    busy;
  logic                    go;
  logic [MODE_W-1:0]       spin;
  logic [MODE_W-1:0]       mode;
  logic                    clr;
  logic                    done;

  assign lc       = item.left_count;
  assign rc       = item.right_count;
  assign ramp_cnt = COUNT_BITS'(RAMP_COUNTS);
  assign kind     = item.cmd[1:0];

  // Targets latched by a start command, saturated to the count width.
  always_comb begin
    case (kind)
      KIND_RIGHT_ABOUT: cr_sel = cfg.cruise_right_about;
      KIND_LEFT_ABOUT:  cr_sel = cfg.cruise_left_about;
      KIND_RIGHT_HALF:  cr_sel = cfg.cruise_half;
      default:          cr_sel = cfg.cruise_back;
    endcase
    dl_sel = (kind == KIND_RIGHT_HALF) ? cfg.decel_half_len : cfg.decel_full;
    ce_sum = SUM_W'(RAMP_COUNTS) + SUM_W'(cr_sel);
    ce_sat = (ce_sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : ce_sum[COUNT_BITS-1:0];
    de_sum = SUM_W'(ce_sat) + SUM_W'(dl_sel);
    de_sat = (de_sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : de_sum[COUNT_BITS-1:0];
  end

  // Accel ramp: table indexed by the left count clamped to the table.
  always_comb begin
    acc_idx   = (lc > COUNT_BITS'(SIG_DEPTH - 1)) ? 8'hFF : lc[7:0];
    acc_sig   = SIG_ROM[acc_idx];
    acc_speed = 8'd70 + acc_sig[15:8];
  end

  // Decel ramp: offset from RAMP_COUNTS before the decel end, rounded up when scaled down.
  always_comb begin
    dec_dif = $signed({2'b00, lc}) + DIF_W'(RAMP_COUNTS) - $signed({2'b00, state.decel_end});
    if (dec_dif < 0) begin
      dec_idx = 8'd0;
    end else if (dec_dif > DIF_W'(SIG_DEPTH - 1)) begin
      dec_idx = 8'hFF;
    end else begin
      dec_idx = dec_dif[7:0];
    end
    dec_sig = SIG_ROM[dec_idx];
    dec_sum = {1'b0, dec_sig} + 17'd255;
    dec_cut = dec_sum[15:8];
  end

  // Phase sequencing; a phase whose exit already holds falls through.
  always_comb begin
    state_nxt = state;
    mode      = MODE_IDLE;
    clr       = 1'b0;
    done      = 1'b0;
    busy      = 1'b1;
    go        = 1'b0;
    spin      = ((state.turn_kind == KIND_RIGHT_ABOUT) ||
                 (state.turn_kind == KIND_RIGHT_HALF)) ? MODE_SPIN_RIGHT : MODE_SPIN_LEFT;

    if (item.cmd <= CMD_TURN_BACK) begin
      state_nxt.turn_kind  = kind;
      state_nxt.cruise_end = ce_sat;
      state_nxt.decel_end  = de_sat;
      state_nxt.left_base  = 8'd70;
      state_nxt.right_base = 8'd70;
      state_nxt.phase      = PH_ACCEL;
      mode = ((kind == KIND_RIGHT_ABOUT) || (kind == KIND_RIGHT_HALF)) ?
             MODE_SPIN_RIGHT : MODE_SPIN_LEFT;
      clr  = 1'b1;
    end else if (item.cmd == CMD_TICK) begin
      if (state_nxt.phase == PH_ACCEL) begin
        if ((rc <= ramp_cnt) || (lc <= ramp_cnt)) begin
          state_nxt.left_base  = acc_speed;
          state_nxt.right_base = acc_speed;
          busy = 1'b0;
        end else begin
          state_nxt.left_base  = 8'd180;
          state_nxt.right_base = 8'd176;
          state_nxt.phase      = PH_CRUISE;
        end
      end
      if (busy && (state_nxt.phase == PH_CRUISE)) begin
        go = (rc <= state.cruise_end) ||
             ((state.turn_kind == KIND_TURN_BACK) && (lc <= state.cruise_end));
        if (go) begin
          busy = 1'b0;
        end else begin
          state_nxt.phase = PH_DECEL;
        end
      end
      if (busy && (state_nxt.phase == PH_DECEL)) begin
        if ((rc <= state.decel_end) || (lc <= state.decel_end)) begin
          state_nxt.left_base  = 8'd180 - dec_cut;
          state_nxt.right_base = 8'd176 - dec_cut;
        end else begin
          if ((state.turn_kind == KIND_RIGHT_ABOUT) || (state.turn_kind == KIND_LEFT_ABOUT)) begin
            state_nxt.left_base  = 8'd130;
            state_nxt.right_base = 8'd128;
          end else begin
            state_nxt.left_base  = 8'd180;
            state_nxt.right_base = 8'd176;
          end
          state_nxt.phase = PH_IDLE;
          mode = MODE_BRAKE;
          clr  = 1'b1;
          done = 1'b1;
        end
      end
      if (state_nxt.phase != PH_IDLE) begin
        mode = spin;
      end
    end else begin
      mode = (state.phase != PH_IDLE) ? spin : MODE_IDLE;
    end
  end

  assign result.left_speed     = state_nxt.left_base;
  assign result.right_speed    = state_nxt.right_base;
  assign result.drive_mode     = mode;
  assign result.clear_encoders = clr;
  assign result.turn_done      = done;

endmodule

`default_nettype wire

// ===== rtl/encoder_turn_speed_sequencer_core.sv =====
// Throughput: one request per cycle while out_tready does not stall the output.
// The input register, the single-pass step logic and the result register form a
// two-stage pipeline with ready flowing backwards.
// Reset (rst_n low, synchronous): both pipeline stages empty, sequencer idle,
// base speeds 130/128 and the configuration registers at their documented defaults.
`default_nettype none

module encoder_turn_speed_sequencer_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Configuration write port.
  input  wire logic                                cfg_we,
  input  wire logic [etss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [etss_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // Input requests.
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [13:0] left_count, [27:14] right_count, [31:28] zero
  input  wire logic [etss_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [2:0] cmd
  input  wire logic [etss_pkg::CMD_W-1:0]          in_tuser,
  // Result requests.
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [7:0] left_speed, [15:8] right_speed, [17:16] drive_mode,
  // [18] clear_encoders, [19] turn_done, [23:20] zero
  output logic [etss_pkg::OUT_TDATA_W-1:0]         out_tdata
);
  import etss_pkg::*;

  seq_cfg_t    cfg_r;
  seq_state_t  state_r;
  seq_state_t  state_nxt;
  seq_item_t   s1_item_r;
  logic        s1_v_r;
  logic        s1_adv;
  seq_result_t step_res;
  seq_result_t out_res_r;
  logic        out_v_r;
  logic        in_acc;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cruise_right_about <= 12'd105;
      cfg_r.cruise_left_about  <= 12'd150;
      cfg_r.cruise_half        <= 12'd1;
      cfg_r.cruise_back        <= 12'd590;
      cfg_r.decel_full         <= 7'd100;
      cfg_r.decel_half_len     <= 7'd80;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CRUISE_RIGHT_ABOUT: cfg_r.cruise_right_about <= cfg_wdata;
        REG_CRUISE_LEFT_ABOUT:  cfg_r.cruise_left_about  <= cfg_wdata;
        REG_CRUISE_HALF:        cfg_r.cruise_half        <= cfg_wdata;
        REG_CRUISE_BACK:        cfg_r.cruise_back        <= cfg_wdata;
        REG_DECEL_FULL:         cfg_r.decel_full         <= cfg_wdata[DECEL_W-1:0];
        REG_DECEL_HALF_LEN:     cfg_r.decel_half_len     <= cfg_wdata[DECEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control.
  assign s1_adv    = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.cmd         <= in_tuser;
      s1_item_r.left_count  <= in_tdata[COUNT_BITS-1:0];
      s1_item_r.right_count <= in_tdata[2*COUNT_BITS-1:COUNT_BITS];
    end
  end

  etss_step u_step (
    .state     (state_r),
    .cfg       (cfg_r),
    .item      (s1_item_r),
    .state_nxt (state_nxt),
    .result    (step_res)
  );

  // Sequencer state advances as each request leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase      <= PH_IDLE;
      state_r.turn_kind  <= KIND_RIGHT_ABOUT;
      state_r.cruise_end <= '0;
      state_r.decel_end  <= '0;
      state_r.left_base  <= 8'd130;
      state_r.right_base <= 8'd128;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'b0000, out_res_r.turn_done, out_res_r.clear_encoders,
                       out_res_r.drive_mode, out_res_r.right_speed, out_res_r.left_speed};

`ifndef SYNTHESIS
  // A finished turn always brakes and clears the encoders.
  a_done_brakes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_res_r.turn_done) |->
      (out_res_r.clear_encoders && (out_res_r.drive_mode == MODE_BRAKE)))
    else $error("turn_done without brake and clear");

  // An encoder clear that is not a finish comes from a start, which spins.
  a_clear_spins: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_res_r.clear_encoders && !out_res_r.turn_done) |->
      ((out_res_r.drive_mode == MODE_SPIN_RIGHT) || (out_res_r.drive_mode == MODE_SPIN_LEFT)))
    else $error("start clear without spin");

  // A start command leaves the sequencer in the accel phase.
  a_start_accel: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_item_r.cmd <= CMD_TURN_BACK)) |=> (state_r.phase == PH_ACCEL))
    else $error("start did not enter accel");

  // The input side only stalls while the input register holds a request and the result register holds one not taken.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_v_r && out_v_r && !out_tready))
    else $error("input stalled with room in the pipeline");
`endif

endmodule

`default_nettype wire
